>>> rtl/hsps_pkg.sv
`timescale 1ns / 1ps

package hsps_pkg;

    // Input item: one byte of the parameter set
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } hsps_in_t;

    // Result item: one per unit, on the last byte
    typedef struct packed {
        logic [20:0] pic_width;
        logic [21:0] pic_height;
        logic [7:0]  profile_id;
        logic [7:0]  level_id;
        logic [1:0]  status;
    } hsps_out_t;

    // Queue entry between the byte front end and the bit parser
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       skip;
    } hsps_entry_t;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNC     = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // Start code length in bytes
    localparam int unsigned START_CODE_BYTES = 4;

    // Profiles that carry the chroma / bit depth / scaling list syntax
    localparam logic [7:0] PROF_HIGH      = 8'd100;
    localparam logic [7:0] PROF_HIGH10    = 8'd110;
    localparam logic [7:0] PROF_HIGH422   = 8'd122;
    localparam logic [7:0] PROF_HIGH444   = 8'd244;
    localparam logic [7:0] PROF_CAVLC444  = 8'd44;
    localparam logic [7:0] PROF_SCAL_BASE = 8'd83;
    localparam logic [7:0] PROF_SCAL_HIGH = 8'd86;
    localparam logic [7:0] PROF_MV_HIGH   = 8'd118;

    function automatic logic is_high_profile(input logic [7:0] p);
        is_high_profile = (p == PROF_HIGH) || (p == PROF_HIGH10) ||
                          (p == PROF_HIGH422) || (p == PROF_HIGH444) ||
                          (p == PROF_CAVLC444) || (p == PROF_SCAL_BASE) ||
                          (p == PROF_SCAL_HIGH) || (p == PROF_MV_HIGH);
    endfunction

endpackage

>>> rtl/hsps_front.sv
`timescale 1ns / 1ps

module hsps_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hsps_pkg::hsps_in_t   in_data,
    output logic                 head_valid,
    output hsps_pkg::hsps_entry_t head,
    input  logic                 pop
);
    import hsps_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    logic              strip_reg;
    logic [2:0]        prefix_reg;
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;
    hsps_entry_t       queue_reg [DEPTH];
    logic              push;
    logic              skip_now;

    assign in_stall   = (count_reg == (PW+1)'(DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];
    assign skip_now   = strip_reg && (prefix_reg < 3'(START_CODE_BYTES));

    // Start code setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strip_reg <= 1'b1;
        else if (cfg_valid)
            strip_reg <= cfg_data;
    end

    // Classify: count start code bytes per unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prefix_reg <= '0;
        else if (push)
        begin
            if (in_data.last_byte)
                prefix_reg <= '0;
            else if (skip_now)
                prefix_reg <= prefix_reg + 3'd1;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= '{data_byte: in_data.data_byte,
                                       last_byte: in_data.last_byte,
                                       skip:      skip_now};
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH)) else $error("queue over depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid) else $error("pop from empty queue");
    a_prefix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_reg <= 3'(START_CODE_BYTES)) else $error("prefix count overrun");

endmodule

>>> rtl/hsps_back.sv
`timescale 1ns / 1ps

module hsps_back #(
    parameter int unsigned FIELD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  hsps_pkg::hsps_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hsps_pkg::hsps_out_t   out_data
);
    import hsps_pkg::*;

    localparam int unsigned FB = FIELD_BITS;
    localparam int unsigned CW = FB + 6;
    localparam int unsigned XW = (CW > 23) ? CW : 23;

    typedef enum logic [5:0] {
        ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPS_ID, ST_CHROMA, ST_RESID,
        ST_BDL, ST_BDC, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DELTA,
        ST_FRAMENUM, ST_POC_TYPE, ST_POC_LSB, ST_POC_ZERO, ST_OFF_NONREF,
        ST_OFF_TB, ST_CYCLE_N, ST_CYCLE_OFF, ST_MAXREF, ST_GAPS, ST_WIDTH,
        ST_HEIGHT, ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT, ST_CROP_FLAG, ST_CROP,
        ST_VUI, ST_DONE
    } step_t;

    typedef enum logic [1:0] {PH_RUN, PH_SUM, PH_EMIT} phase_t;

    // Parser state
    step_t         step_reg, step_next;
    phase_t        phase_reg, phase_next;
    logic [2:0]    bit_idx_reg, bit_idx_next;
    logic [2:0]    byte_cnt_reg, byte_cnt_next;
    logic [7:0]    byte_sr_reg, byte_sr_next;
    logic [5:0]    zero_run_reg, zero_run_next;
    logic [5:0]    suffix_reg, suffix_next;
    logic [FB:0]   acc_reg, acc_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    profile_reg, profile_next;
    logic [7:0]    level_reg, level_next;
    logic          chroma444_reg, chroma444_next;
    logic [3:0]    list_reg, list_next;
    logic [6:0]    entry_reg, entry_next;
    logic [7:0]    last_scale_reg, last_scale_next;
    logic [FB-1:0] cycle_reg, cycle_next;
    logic [FB-1:0] width_reg, width_next;
    logic [FB-1:0] height_reg, height_next;
    logic          frame_only_reg, frame_only_next;
    logic [FB-1:0] crop_reg [4];
    logic [FB-1:0] crop_val;
    logic [1:0]    crop_idx;
    logic          crop_we;

    // Size pipeline and output
    logic [XW-1:0] fw_reg, fh_reg, cw_reg, ch_reg;
    logic          done_reg;
    logic          out_valid_reg;
    hsps_out_t     out_reg;

    // Per-bit signals
    logic          bit_val;
    logic          take;
    logic          byte_end;
    logic          ue_done;
    logic [FB-1:0] ue_val;
    logic [FB+8:0] ue_ext;
    logic [7:0]    delta;
    logic [7:0]    scale_sum;
    logic [3:0]    list_inc;
    logic [6:0]    entry_inc;
    logic          slot_free;
    logic [XW-1:0] w_diff, h_diff;
    logic          w_under, h_under;

    assign bit_val   = head.data_byte[3'd7 - bit_idx_reg];
    assign take      = (phase_reg == PH_RUN) && head_valid && !head.skip;
    assign byte_end  = (phase_reg == PH_RUN) && head_valid &&
                       (head.skip || bit_idx_reg == 3'd7);
    assign pop       = byte_end;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Exp-Golomb bit step; value saturates at all ones
    always_comb
    begin
        zero_run_next = zero_run_reg;
        suffix_next   = suffix_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        ue_done       = 1'b0;
        ue_val        = '0;
        if (suffix_reg == '0)
        begin
            if (!bit_val && zero_run_reg < 6'd32)
                zero_run_next = zero_run_reg + 6'd1;
            else if (zero_run_reg == '0)
                ue_done = 1'b1;
            else
            begin
                suffix_next = zero_run_reg;
                acc_next    = (FB+1)'(1);
                ovf_next    = 1'b0;
            end
        end
        else
        begin
            acc_next    = {acc_reg[FB-1:0], bit_val};
            ovf_next    = ovf_reg | acc_reg[FB];
            suffix_next = suffix_reg - 6'd1;
            if (suffix_reg == 6'd1)
            begin
                ue_done = 1'b1;
                if (ovf_next || (acc_next[FB] && |acc_next[FB-1:0]))
                    ue_val = '1;
                else
                    ue_val = FB'(acc_next - (FB+1)'(1));
                zero_run_next = '0;
                acc_next      = '0;
                ovf_next      = 1'b0;
            end
        end
    end

    // Scaling list delta, taken mod 256
    assign ue_ext    = (FB+9)'(ue_val);
    assign delta     = ue_ext[0] ? (ue_ext[8:1] + 8'd1) : (8'd0 - ue_ext[8:1]);
    assign scale_sum = last_scale_reg + delta;
    assign list_inc  = list_reg + 4'd1;
    assign entry_inc = entry_reg + 7'd1;

    // Syntax walk
    always_comb
    begin
        step_next       = step_reg;
        phase_next      = phase_reg;
        bit_idx_next    = bit_idx_reg;
        byte_cnt_next   = byte_cnt_reg;
        byte_sr_next    = byte_sr_reg;
        profile_next    = profile_reg;
        level_next      = level_reg;
        chroma444_next  = chroma444_reg;
        list_next       = list_reg;
        entry_next      = entry_reg;
        last_scale_next = last_scale_reg;
        cycle_next      = cycle_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        frame_only_next = frame_only_reg;
        crop_we         = 1'b0;
        crop_idx        = list_reg[1:0];
        crop_val        = ue_val;

        if (take)
        begin
            bit_idx_next = bit_idx_reg + 3'd1;
            unique case (step_reg)
                ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL:
                begin
                    byte_sr_next  = {byte_sr_reg[6:0], bit_val};
                    byte_cnt_next = byte_cnt_reg + 3'd1;
                    if (byte_cnt_reg == 3'd7)
                    begin
                        unique case (step_reg)
                            ST_HDR:     step_next = ST_PROFILE;
                            ST_PROFILE:
                            begin
                                profile_next = byte_sr_next;
                                step_next    = ST_CONSTR;
                            end
                            ST_CONSTR:  step_next = ST_LEVEL;
                            default:
                            begin
                                level_next = byte_sr_next;
                                step_next  = ST_SPS_ID;
                            end
                        endcase
                    end
                end
                ST_SPS_ID:
                    if (ue_done)
                        step_next = is_high_profile(profile_reg) ? ST_CHROMA : ST_FRAMENUM;
                ST_CHROMA:
                    if (ue_done)
                    begin
                        chroma444_next = (ue_val == FB'(3));
                        step_next      = (ue_val == FB'(3)) ? ST_RESID : ST_BDL;
                    end
                ST_RESID:  step_next = ST_BDL;
                ST_BDL:    if (ue_done) step_next = ST_BDC;
                ST_BDC:    if (ue_done) step_next = ST_BYPASS;
                ST_BYPASS: step_next = ST_MATRIX;
                ST_MATRIX:
                    if (bit_val)
                    begin
                        list_next = '0;
                        step_next = ST_LIST_FLAG;
                    end
                    else
                        step_next = ST_FRAMENUM;
                ST_LIST_FLAG:
                    if (bit_val)
                    begin
                        last_scale_next = 8'd8;
                        entry_next      = '0;
                        step_next       = ST_DELTA;
                    end
                    else
                    begin
                        list_next = list_inc;
                        step_next = (list_inc >= (chroma444_reg ? 4'd12 : 4'd8)) ?
                                    ST_FRAMENUM : ST_LIST_FLAG;
                    end
                ST_DELTA:
                    if (ue_done)
                    begin
                        if (scale_sum != 8'd0)
                            last_scale_next = scale_sum;
                        entry_next = entry_inc;
                        if (scale_sum == 8'd0 ||
                            entry_inc >= ((list_reg < 4'd6) ? 7'd16 : 7'd64))
                        begin
                            list_next = list_inc;
                            step_next = (list_inc >= (chroma444_reg ? 4'd12 : 4'd8)) ?
                                        ST_FRAMENUM : ST_LIST_FLAG;
                        end
                    end
                ST_FRAMENUM: if (ue_done) step_next = ST_POC_TYPE;
                ST_POC_TYPE:
                    if (ue_done)
                        step_next = (ue_val == '0) ? ST_POC_LSB :
                                    (ue_val == FB'(1)) ? ST_POC_ZERO : ST_MAXREF;
                ST_POC_LSB:    if (ue_done) step_next = ST_MAXREF;
                ST_POC_ZERO:   step_next = ST_OFF_NONREF;
                ST_OFF_NONREF: if (ue_done) step_next = ST_OFF_TB;
                ST_OFF_TB:     if (ue_done) step_next = ST_CYCLE_N;
                ST_CYCLE_N:
                    if (ue_done)
                    begin
                        cycle_next = ue_val;
                        step_next  = (ue_val != '0) ? ST_CYCLE_OFF : ST_MAXREF;
                    end
                ST_CYCLE_OFF:
                    if (ue_done)
                    begin
                        cycle_next = cycle_reg - FB'(1);
                        if (cycle_reg == FB'(1))
                            step_next = ST_MAXREF;
                    end
                ST_MAXREF: if (ue_done) step_next = ST_GAPS;
                ST_GAPS:   step_next = ST_WIDTH;
                ST_WIDTH:
                    if (ue_done)
                    begin
                        width_next = ue_val;
                        step_next  = ST_HEIGHT;
                    end
                ST_HEIGHT:
                    if (ue_done)
                    begin
                        height_next = ue_val;
                        step_next   = ST_FRAME_ONLY;
                    end
                ST_FRAME_ONLY:
                begin
                    frame_only_next = bit_val;
                    step_next       = bit_val ? ST_DIRECT : ST_MBAFF;
                end
                ST_MBAFF:  step_next = ST_DIRECT;
                ST_DIRECT: step_next = ST_CROP_FLAG;
                ST_CROP_FLAG:
                    if (bit_val)
                    begin
                        list_next = '0;
                        step_next = ST_CROP;
                    end
                    else
                        step_next = ST_VUI;
                ST_CROP:
                    if (ue_done)
                    begin
                        crop_we   = 1'b1;
                        list_next = list_inc;
                        if (list_inc >= 4'd4)
                            step_next = ST_VUI;
                    end
                ST_VUI:  step_next = ST_DONE;
                ST_DONE: step_next = ST_DONE;
                default: step_next = ST_DONE;
            endcase
        end

        // Unit end: sum, then emit
        unique case (phase_reg)
            PH_RUN:  if (byte_end && head.last_byte) phase_next = PH_SUM;
            PH_SUM:  phase_next = PH_EMIT;
            PH_EMIT: if (slot_free) phase_next = PH_RUN;
            default: phase_next = PH_RUN;
        endcase
    end

    // Exp-Golomb registers update only in exp-Golomb steps
    function automatic logic is_ue_step(input step_t s);
        is_ue_step = (s == ST_SPS_ID) || (s == ST_CHROMA) || (s == ST_BDL) ||
                     (s == ST_BDC) || (s == ST_DELTA) || (s == ST_FRAMENUM) ||
                     (s == ST_POC_TYPE) || (s == ST_POC_LSB) || (s == ST_OFF_NONREF) ||
                     (s == ST_OFF_TB) || (s == ST_CYCLE_N) || (s == ST_CYCLE_OFF) ||
                     (s == ST_MAXREF) || (s == ST_WIDTH) || (s == ST_HEIGHT) ||
                     (s == ST_CROP);
    endfunction

    // Underflow check and subtraction
    assign w_under = cw_reg > fw_reg;
    assign h_under = ch_reg > fh_reg;
    assign w_diff  = fw_reg - cw_reg;
    assign h_diff  = fh_reg - ch_reg;

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_HDR;
            phase_reg      <= PH_RUN;
            bit_idx_reg    <= '0;
            byte_cnt_reg   <= '0;
            byte_sr_reg    <= '0;
            zero_run_reg   <= '0;
            suffix_reg     <= '0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            profile_reg    <= '0;
            level_reg      <= '0;
            chroma444_reg  <= 1'b0;
            list_reg       <= '0;
            entry_reg      <= '0;
            last_scale_reg <= 8'd8;
            cycle_reg      <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            frame_only_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                crop_reg[i] <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (phase_reg == PH_EMIT && slot_free)
            begin
                // Deliver and rearm for the next unit
                out_valid_reg  <= 1'b1;
                step_reg       <= ST_HDR;
                phase_reg      <= PH_RUN;
                bit_idx_reg    <= '0;
                byte_cnt_reg   <= '0;
                byte_sr_reg    <= '0;
                zero_run_reg   <= '0;
                suffix_reg     <= '0;
                acc_reg        <= '0;
                ovf_reg        <= 1'b0;
                profile_reg    <= '0;
                level_reg      <= '0;
                chroma444_reg  <= 1'b0;
                list_reg       <= '0;
                entry_reg      <= '0;
                last_scale_reg <= 8'd8;
                cycle_reg      <= '0;
                width_reg      <= '0;
                height_reg     <= '0;
                frame_only_reg <= 1'b0;
                for (int i = 0; i < 4; i++)
                    crop_reg[i] <= '0;
            end
            else
            begin
                // Result taken by the receiver
                if (!out_stall)
                    out_valid_reg <= 1'b0;
                step_reg       <= step_next;
                phase_reg      <= phase_next;
                bit_idx_reg    <= bit_idx_next;
                byte_cnt_reg   <= byte_cnt_next;
                byte_sr_reg    <= byte_sr_next;
                if (take && is_ue_step(step_reg))
                begin
                    zero_run_reg <= zero_run_next;
                    suffix_reg   <= suffix_next;
                    acc_reg      <= acc_next;
                    ovf_reg      <= ovf_next;
                end
                profile_reg    <= profile_next;
                level_reg      <= level_next;
                chroma444_reg  <= chroma444_next;
                list_reg       <= list_next;
                entry_reg      <= entry_next;
                last_scale_reg <= last_scale_next;
                cycle_reg      <= cycle_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                frame_only_reg <= frame_only_next;
                if (crop_we)
                    crop_reg[crop_idx] <= crop_val;
            end
        end
    end

    // Frame and crop sizes, registered in the sum phase ahead of the compare
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_SUM)
        begin
            done_reg <= (step_reg == ST_DONE);
            fw_reg   <= XW'({1'b0, width_reg} + (FB+1)'(1)) << 4;
            fh_reg   <= XW'({1'b0, height_reg} + (FB+1)'(1)) << (frame_only_reg ? 4 : 5);
            cw_reg   <= (XW'(crop_reg[0]) + XW'(crop_reg[1])) << 1;
            ch_reg   <= (XW'(crop_reg[2]) + XW'(crop_reg[3])) << 1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_EMIT && slot_free)
        begin
            out_reg.profile_id <= profile_reg;
            out_reg.level_id   <= level_reg;
            if (!done_reg)
            begin
                out_reg.pic_width  <= '0;
                out_reg.pic_height <= '0;
                out_reg.status     <= STATUS_TRUNC;
            end
            else
            begin
                out_reg.status <= (w_under || h_under) ? STATUS_UNDERFLOW : STATUS_OK;
                if (w_under)
                    out_reg.pic_width <= '0;
                else if (w_diff > XW'(21'h1FFFFF))
                    out_reg.pic_width <= '1;
                else
                    out_reg.pic_width <= w_diff[20:0];
                if (h_under)
                    out_reg.pic_height <= '0;
                else if (h_diff > XW'(22'h3FFFFF))
                    out_reg.pic_height <= '1;
                else
                    out_reg.pic_height <= h_diff[21:0];
            end
        end
    end

    a_no_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_RUN) |-> !pop) else $error("byte consumed during result");
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EMIT && slot_free) |=> out_valid_reg && step_reg == ST_HDR)
        else $error("result not loaded");
    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STATUS_TRUNC) |->
        (out_reg.pic_width == '0 && out_reg.pic_height == '0))
        else $error("truncated result with size");
    a_sum_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last_byte) |=> phase_reg == PH_SUM)
        else $error("last byte did not close unit");

endmodule

>>> rtl/h264_sps_size_parser_core.sv
`timescale 1ns / 1ps
// H.264 sequence parameter set size parser.
// Input channel (in_valid / in_stall / in_data): one byte per transfer,
// MSB first, last_byte marks the final byte of a unit. A four entry queue
// sits between the byte front end and the bit parser, so bytes are taken
// while the parser works and while a result waits.
// Output channel (out_valid / out_stall / out_data): one result per unit,
// sent after the byte marked last: size, profile, level and status.
// Config channel (cfg_valid / cfg_ready / cfg_data): start code strip bit,
// always ready; write it only while no unit is in flight.
// Throughput: the parser takes one bit per cycle while a byte waits in the
// queue and no unit end is pending; a start code byte is dropped whole.
// After the last byte the parser passes a sum phase and then an emit phase
// for the size compare before the result is loaded into the output register.
// A stalled result holds its value; the parser then waits at unit end and
// the queue keeps taking bytes until it is full, then in_stall rises.
// Reset clears the queue, the parser and the output, and sets stripping on.

module h264_sps_size_parser_core #(
    parameter int unsigned FIELD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  hsps_pkg::hsps_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output hsps_pkg::hsps_out_t out_data
);
    import hsps_pkg::*;

    logic        head_valid;
    hsps_entry_t head;
    logic        pop;

    assign cfg_ready = 1'b1;

    // Byte front end and queue
    hsps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Bit parser and result register
    hsps_back #(
        .FIELD_BITS (FIELD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
